FILE: rtl/core/lpg_pkg.sv
// lpg_pkg: shared types, register map and helper function for the led pattern generator
// used by lpg_engine and led_pattern_generator; depends on nothing
`timescale 1ns / 1ps

package lpg_pkg;

    // register map, index = paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_PATTERN_MODE   = 3'd0;
    localparam logic [2:0] REG_COLOR_MODE     = 3'd1;
    localparam logic [2:0] REG_BLINK_ON_MS    = 3'd2;
    localparam logic [2:0] REG_BLINK_OFF_MS   = 3'd3;
    localparam logic [2:0] REG_BREATH_STEP_MS = 3'd4;

    // pattern codes
    localparam logic [1:0] PAT_OFF       = 2'd0;
    localparam logic [1:0] PAT_ON        = 2'd1;
    localparam logic [1:0] PAT_BLINK     = 2'd2;
    localparam logic [1:0] PAT_BREATHING = 2'd3;

    // colour codes
    localparam logic [1:0] COLOR_RED    = 2'd0;
    localparam logic [1:0] COLOR_GREEN  = 2'd1;
    localparam logic [1:0] COLOR_YELLOW = 2'd2;

    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] YELLOW_NUM = 8'd203;

    // register reset values
    localparam logic [1:0]  RST_PATTERN_MODE   = PAT_ON;
    localparam logic [1:0]  RST_COLOR_MODE     = COLOR_YELLOW;
    localparam logic [15:0] RST_BLINK_ON_MS    = 16'd500;
    localparam logic [15:0] RST_BLINK_OFF_MS   = 16'd500;
    localparam logic [7:0]  RST_BREATH_STEP_MS = 8'd5;

    typedef struct packed {
        logic [1:0]  pattern_mode;
        logic [1:0]  color_mode;
        logic [15:0] blink_on_ms;
        logic [15:0] blink_off_ms;
        logic [7:0]  breath_step_ms;
    } t_cfg;

    typedef struct packed {
        logic        blink_phase_on;
        logic [31:0] blink_start_ms;
        logic [31:0] blink_total;
        logic [31:0] breath_start_ms;
        logic [7:0]  breath_level;
        logic        breath_rising;
        logic [7:0]  red_target;
        logic [7:0]  green_target;
    } t_state;

    typedef struct packed {
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic        red_changed;
        logic        green_changed;
        logic [31:0] blinks_done;
    } t_result;

    // floor(v * 203 / 255): quotient by 256 first, then one correction step
    function automatic logic [7:0] yellow_mix(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [9:0]  rem;
        logic [7:0]  res;
        prod = {8'd0, v} * {8'd0, YELLOW_NUM};
        q    = prod[15:8];
        rem  = {2'b00, prod[7:0]} + {2'b00, q};
        res  = (rem >= 10'd255) ? q + 8'd1 : q;
        return res;
    endfunction

endpackage

FILE: rtl/core/led_pattern_generator.sv
// led_pattern_generator: top level with apb register file, tick input stage and result register
// depends on lpg_pkg and lpg_engine
`timescale 1ns / 1ps

// Each request on the input channel is one timer tick carrying the current
// millisecond timestamp; it yields exactly one result with the red and green
// brightness levels for a two-colour led, a changed flag per colour and the
// running count of completed blink on-phases. A tick enters an input register,
// passes through one layer of combinational pattern logic (a 32-bit elapsed
// compare, a clamped ramp step and the constant yellow scaling) and lands in
// the result register. One tick is taken every cycle unless the output stalls;
// the only loop is the pattern state register, updated in the same
// cycle the tick moves into the result register. The result register frees
// itself in the cycle its contents are taken, so a stalled output holds up
// at most the one tick waiting in the input register. Configuration lives in
// an apb register file (pattern, colour, blink on/off times, breathing step)
// and must be written only while no tick is in flight.

module led_pattern_generator
    import lpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // tick input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_now_ms,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_red_level,
    output logic [7:0]        o_green_level,
    output logic              o_red_changed,
    output logic              o_green_changed,
    output logic [31:0]       o_blinks_done
);

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    logic        r_s1_valid;
    logic [31:0] r_s1_now;
    logic        r_out_valid;
    logic [7:0]  r_red_level;
    logic [7:0]  r_green_level;
    logic        r_red_changed;
    logic        r_green_changed;
    logic [31:0] r_blinks_done;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic        advance;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_mode   <= RST_PATTERN_MODE;
            r_cfg.color_mode     <= RST_COLOR_MODE;
            r_cfg.blink_on_ms    <= RST_BLINK_ON_MS;
            r_cfg.blink_off_ms   <= RST_BLINK_OFF_MS;
            r_cfg.breath_step_ms <= RST_BREATH_STEP_MS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PATTERN_MODE:   r_cfg.pattern_mode   <= pwdata[1:0];
                REG_COLOR_MODE:     r_cfg.color_mode     <= pwdata[1:0];
                REG_BLINK_ON_MS:    r_cfg.blink_on_ms    <= pwdata[15:0];
                REG_BLINK_OFF_MS:   r_cfg.blink_off_ms   <= pwdata[15:0];
                REG_BREATH_STEP_MS: r_cfg.breath_step_ms <= pwdata[7:0];
                default: begin
                    // writes outside the map are dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PATTERN_MODE:   prdata = {30'd0, r_cfg.pattern_mode};
            REG_COLOR_MODE:     prdata = {30'd0, r_cfg.color_mode};
            REG_BLINK_ON_MS:    prdata = {16'd0, r_cfg.blink_on_ms};
            REG_BLINK_OFF_MS:   prdata = {16'd0, r_cfg.blink_off_ms};
            REG_BREATH_STEP_MS: prdata = {24'd0, r_cfg.breath_step_ms};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    // the input stage moves on whenever the result register is empty or being drained
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_now <= i_now_ms;
        end
    end

    // ---------------- pattern logic ----------------
    lpg_engine u_engine (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_now_ms (r_s1_now),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // pattern state only advances together with the tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_red_level     <= n_result.red_level;
            r_green_level   <= n_result.green_level;
            r_red_changed   <= n_result.red_changed;
            r_green_changed <= n_result.green_changed;
            r_blinks_done   <= n_result.blinks_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red_level     = r_red_level;
    assign o_green_level   = r_green_level;
    assign o_red_changed   = r_red_changed;
    assign o_green_changed = r_green_changed;
    assign o_blinks_done   = r_blinks_done;

    // ---------------- checks ----------------
    // state holds between ticks
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("pattern state changed without a tick");

    // blink count moves by at most one per tick
    a_blink_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_state.blink_total == $past(r_state.blink_total)) ||
                    (r_state.blink_total == $past(r_state.blink_total) + 32'd1))
        else $error("blink count jumped");

    // changed flags compare against the previous emitted level
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_red_changed == (o_red_level != $past(r_state.red_target))) &&
                    (o_green_changed == (o_green_level != $past(r_state.green_target))))
        else $error("changed flag inconsistent with level history");

    // result register mirrors the committed state
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_red_level == r_state.red_target) &&
                    (o_blinks_done == r_state.blink_total))
        else $error("result register out of step with pattern state");

endmodule

FILE: rtl/core/lpg_engine.sv
// lpg_engine: one tick of the pattern state machine, purely combinational
// depends on lpg_pkg for the config, state and result types
`timescale 1ns / 1ps

module lpg_engine
    import lpg_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic [31:0] i_now_ms,
    output t_state      o_state,
    output t_result     o_result
);

    logic        apply;
    logic [7:0]  value;
    logic [31:0] blink_age;
    logic [31:0] breath_age;
    logic [31:0] blink_dur;
    logic        blink_due;
    logic        breath_due;
    logic [7:0]  lvl;

    assign blink_age  = i_now_ms - i_state.blink_start_ms;
    assign breath_age = i_now_ms - i_state.breath_start_ms;
    assign blink_dur  = i_state.blink_phase_on ? {16'd0, i_cfg.blink_on_ms}
                                               : {16'd0, i_cfg.blink_off_ms};
    assign blink_due  = blink_age >= blink_dur;
    assign breath_due = breath_age >= {24'd0, i_cfg.breath_step_ms};

    // clamped ramp step
    always_comb begin
        lvl = i_state.breath_level;
        if (i_state.breath_rising) begin
            if (lvl != LEVEL_FULL) lvl = lvl + 8'd1;
        end else begin
            if (lvl != 8'd0) lvl = lvl - 8'd1;
        end
    end

    always_comb begin
        o_state = i_state;
        apply   = 1'b0;
        value   = 8'd0;
        case (i_cfg.pattern_mode)
            PAT_OFF: begin
                apply = 1'b1;
                value = 8'd0;
            end
            PAT_ON: begin
                apply = 1'b1;
                value = LEVEL_FULL;
            end
            PAT_BLINK: begin
                if (blink_due) begin
                    apply                  = 1'b1;
                    o_state.blink_start_ms = i_now_ms;
                    o_state.blink_phase_on = !i_state.blink_phase_on;
                    if (i_state.blink_phase_on) begin
                        o_state.blink_total = i_state.blink_total + 32'd1;
                        value               = 8'd0;
                    end else begin
                        value = LEVEL_FULL;
                    end
                end
            end
            default: begin
                if (breath_due) begin
                    apply                   = 1'b1;
                    value                   = lvl;
                    o_state.breath_start_ms = i_now_ms;
                    o_state.breath_level    = lvl;
                    if (lvl == 8'd0) begin
                        o_state.breath_rising = 1'b1;
                    end else if (lvl == LEVEL_FULL) begin
                        o_state.breath_rising = 1'b0;
                    end
                end
            end
        endcase

        if (apply) begin
            case (i_cfg.color_mode)
                COLOR_RED: begin
                    o_state.red_target   = value;
                    o_state.green_target = 8'd0;
                end
                COLOR_GREEN: begin
                    o_state.red_target   = 8'd0;
                    o_state.green_target = value;
                end
                COLOR_YELLOW: begin
                    o_state.red_target   = yellow_mix(value);
                    o_state.green_target = yellow_mix(value);
                end
                default: begin
                    // unused colour code leaves the targets alone
                end
            endcase
        end
    end

    assign o_result.red_level     = o_state.red_target;
    assign o_result.green_level   = o_state.green_target;
    assign o_result.red_changed   = o_state.red_target != i_state.red_target;
    assign o_result.green_changed = o_state.green_target != i_state.green_target;
    assign o_result.blinks_done   = o_state.blink_total;

endmodule

FILE: tb/tb_led_pattern_generator.sv
// tb_led_pattern_generator: self-checking testbench for the led pattern generator
// drives timer ticks and apb register writes, predicts every result; depends on lpg_pkg
`timescale 1ns / 1ps

module tb_led_pattern_generator
    import lpg_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned YELLOW_DEN  = 255;
    // colour code with no mapping, the targets must hold
    localparam logic [1:0]  COLOR_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [31:0]       i_now_ms = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_red_level;
    logic [7:0]        o_green_level;
    logic              o_red_changed;
    logic              o_green_changed;
    logic [31:0]       o_blinks_done;

    led_pattern_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_red_level     (o_red_level),
        .o_green_level   (o_green_level),
        .o_red_changed   (o_red_changed),
        .o_green_changed (o_green_changed),
        .o_blinks_done   (o_blinks_done)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the register file, as last written
    logic [1:0]  cfg_pattern = RST_PATTERN_MODE;
    logic [1:0]  cfg_color   = RST_COLOR_MODE;
    logic [15:0] cfg_on_ms   = RST_BLINK_ON_MS;
    logic [15:0] cfg_off_ms  = RST_BLINK_OFF_MS;
    logic [7:0]  cfg_step_ms = RST_BREATH_STEP_MS;

    // predicted pattern state
    logic        lit_phase    = 1'b0;
    logic [31:0] blink_mark   = '0;
    logic [31:0] lit_tally    = '0;
    logic [31:0] breath_mark  = '0;
    logic [7:0]  ramp_level   = '0;
    logic        ramp_up      = 1'b0;
    logic [7:0]  red_goal     = '0;
    logic [7:0]  green_goal   = '0;
    logic [7:0]  red_shown    = '0;
    logic [7:0]  green_shown  = '0;

    t_result     expected_levels[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // sender burst shaping and the running millisecond clock of the stimulus
    int unsigned burst_left = 0;
    logic [31:0] tick_clock = '0;

    // receiver stall pattern: a mode held for a random stretch of cycles
    int unsigned ready_mode = 0;
    int unsigned ready_hold = 0;

    // brightness value onto the two colour targets
    function automatic void map_level(input logic [7:0] v);
        int unsigned mix;
        mix = (32'(v) * 32'(YELLOW_NUM)) / YELLOW_DEN;
        case (cfg_color)
            COLOR_RED: begin
                red_goal   = v;
                green_goal = '0;
            end
            COLOR_GREEN: begin
                red_goal   = '0;
                green_goal = v;
            end
            COLOR_YELLOW: begin
                red_goal   = mix[7:0];
                green_goal = mix[7:0];
            end
            default: begin
            end
        endcase
    endfunction

    // advance the predicted state by one tick and return the result it yields
    function automatic t_result predict_tick(input logic [31:0] now);
        t_result     r;
        logic [31:0] since_blink;
        logic [31:0] since_breath;
        since_blink  = now - blink_mark;
        since_breath = now - breath_mark;
        case (cfg_pattern)
            PAT_OFF: map_level('0);
            PAT_ON:  map_level(LEVEL_FULL);
            PAT_BLINK: begin
                if (lit_phase) begin
                    if (since_blink >= 32'(cfg_on_ms)) begin
                        blink_mark = now;
                        lit_phase  = 1'b0;
                        lit_tally  = lit_tally + 32'd1;
                        map_level('0);
                    end
                end else if (since_blink >= 32'(cfg_off_ms)) begin
                    blink_mark = now;
                    lit_phase  = 1'b1;
                    map_level(LEVEL_FULL);
                end
            end
            default: begin
                if (since_breath >= 32'(cfg_step_ms)) begin
                    breath_mark = now;
                    // clamped ramp step, direction flips at either end
                    if (ramp_up) begin
                        if (ramp_level != LEVEL_FULL) ramp_level = ramp_level + 8'd1;
                    end else if (ramp_level != 8'd0) begin
                        ramp_level = ramp_level - 8'd1;
                    end
                    if (ramp_level == 8'd0) ramp_up = 1'b1;
                    else if (ramp_level == LEVEL_FULL) ramp_up = 1'b0;
                    map_level(ramp_level);
                end
            end
        endcase
        r.red_level     = red_goal;
        r.green_level   = green_goal;
        r.red_changed   = (red_goal != red_shown);
        r.green_changed = (green_goal != green_shown);
        r.blinks_done   = lit_tally;
        red_shown       = red_goal;
        green_shown     = green_goal;
        return r;
    endfunction

    // receiver side: ready changes only at the falling edge
    always @(negedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(16, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= $urandom_range(0, 1);
            2: i_out_ready <= ($urandom_range(0, 7) != 0);
            default: i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // result checker and run watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_levels.size() == 0) begin
                $error("result with no request outstanding: red %0d green %0d",
                       o_red_level, o_green_level);
                error_count++;
            end else begin
                want = expected_levels.pop_front();
                if (o_red_level !== want.red_level) begin
                    $error("red_level: expected %0d, got %0d", want.red_level, o_red_level);
                    error_count++;
                end
                if (o_green_level !== want.green_level) begin
                    $error("green_level: expected %0d, got %0d",
                           want.green_level, o_green_level);
                    error_count++;
                end
                if (o_red_changed !== want.red_changed) begin
                    $error("red_changed: expected %0d, got %0d",
                           want.red_changed, o_red_changed);
                    error_count++;
                end
                if (o_green_changed !== want.green_changed) begin
                    $error("green_changed: expected %0d, got %0d",
                           want.green_changed, o_green_changed);
                    error_count++;
                end
                if (o_blinks_done !== want.blinks_done) begin
                    $error("blinks_done: expected %0d, got %0d",
                           want.blinks_done, o_blinks_done);
                    error_count++;
                end
            end
        end
    end

    // one tick request; entered and left at a falling edge, valid held until taken
    task automatic send_tick(input logic [31:0] now);
        i_in_valid <= 1'b1;
        i_now_ms   <= now;
        do @(posedge i_clk); while (!o_in_ready);
        expected_levels.push_back(predict_tick(now));
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        while (expected_levels.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write with junk above the field, then read back the masked value
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value,
                             input int unsigned width);
        logic [31:0] mask;
        logic [31:0] data;
        logic [31:0] got;
        mask = (32'd1 << width) - 32'd1;
        data = ($urandom() & ~mask) | (value & mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PATTERN_MODE:   cfg_pattern = data[1:0];
            REG_COLOR_MODE:     cfg_color   = data[1:0];
            REG_BLINK_ON_MS:    cfg_on_ms   = data[15:0];
            REG_BLINK_OFF_MS:   cfg_off_ms  = data[15:0];
            REG_BREATH_STEP_MS: cfg_step_ms = data[7:0];
            default: begin
            end
        endcase
        // read setup follows straight on with psel held
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== (data & mask)) begin
            $error("prdata reg %0d: expected %0h, got %0h", idx, data & mask, got);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // full register set, only once the block has gone quiet
    task automatic load_config(input logic [1:0] pat, input logic [1:0] col,
                               input logic [15:0] on_ms, input logic [15:0] off_ms,
                               input logic [7:0] step_ms);
        drain_ticks();
        write_reg(REG_PATTERN_MODE, 32'(pat), 2);
        write_reg(REG_COLOR_MODE, 32'(col), 2);
        write_reg(REG_BLINK_ON_MS, 32'(on_ms), 16);
        write_reg(REG_BLINK_OFF_MS, 32'(off_ms), 16);
        write_reg(REG_BREATH_STEP_MS, 32'(step_ms), 8);
        @(negedge i_clk);
    endtask

    // ticks on a running clock with random steps, some as wild timestamps
    task automatic run_ticks(input int unsigned n, input int unsigned max_inc,
                             input int unsigned noise_pct);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                send_tick($urandom());
            end else begin
                tick_clock = tick_clock + $urandom_range(0, max_inc);
                send_tick(tick_clock);
            end
        end
    endtask

    // durations: mostly short so phases turn over, sometimes the extremes
    function automatic logic [15:0] pick_ms();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return 16'd0;
        else if (roll == 1) return 16'hFFFF;
        else return 16'($urandom_range(0, 40));
    endfunction

    // values straight after reset: full on in yellow
    task automatic test_reset_defaults();
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
    endtask

    task automatic test_directed_patterns();
        load_config(PAT_OFF, COLOR_RED, 16'd0, 16'd0, 8'd0);
        send_tick(32'h0000_0010);
        load_config(PAT_ON, COLOR_RED, 16'd0, 16'd0, 8'd0);
        send_tick(32'h0000_0020);
        load_config(PAT_ON, COLOR_GREEN, 16'd0, 16'd0, 8'd0);
        send_tick(32'h0000_0030);
        // unmapped colour code leaves the targets alone
        load_config(PAT_OFF, COLOR_UNUSED, 16'd0, 16'd0, 8'd0);
        send_tick(32'h0000_0040);
        // zero durations: the blink flips on every tick
        load_config(PAT_BLINK, COLOR_YELLOW, 16'd0, 16'd0, 8'd0);
        repeat (4) send_tick(32'h1234_5678);
        // longest durations across the timestamp wrap
        load_config(PAT_BLINK, COLOR_RED, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_tick(32'hFFFF_0000);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_FFFE);
        send_tick(32'h0000_FFFF);
        // slowest breathing step: due, then not yet due, then due over the wrap
        load_config(PAT_BREATHING, COLOR_GREEN, 16'd0, 16'd0, 8'hFF);
        send_tick(32'hFFFF_FF80);
        send_tick(32'h0000_007E);
        send_tick(32'h0000_007F);
    endtask

    task automatic test_blink_random();
        for (int unsigned p = 0; p < 4; p++) begin
            load_config(PAT_BLINK, 2'($urandom_range(0, 2)), pick_ms(), pick_ms(),
                        8'($urandom()));
            if (p == 3) tick_clock = 32'hFFFF_FF00;
            run_ticks(50, 12, 5);
        end
    endtask

    // zero step ramps every tick, long enough to hit both clamps
    task automatic test_breathing_ramp();
        load_config(PAT_BREATHING, COLOR_YELLOW, pick_ms(), pick_ms(), 8'd0);
        run_ticks(600, 3, 0);
        for (int unsigned p = 0; p < 2; p++) begin
            load_config(PAT_BREATHING, 2'($urandom_range(0, 3)), pick_ms(), pick_ms(),
                        8'($urandom_range(1, 12)));
            run_ticks(50, 20, 5);
        end
    endtask

    task automatic test_mixed_random();
        for (int unsigned p = 0; p < 6; p++) begin
            load_config(2'($urandom()), 2'($urandom()), pick_ms(), pick_ms(),
                        ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 10)));
            tick_clock = $urandom();
            run_ticks(50, 15, 10);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_patterns();
        test_blink_random();
        test_breathing_ramp();
        test_mixed_random();

        // every result in, then idle on to catch anything extra
        drain_ticks();
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
